// ===== rtl/prefixed_utf8_to_utf16_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed UTF-8 to UTF-16 decoder
// Shared concurrent property forms, sampled on the rising clock edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PREFIXED_UTF8_TO_UTF16_DECODER_ASSERT_SVH
`define PREFIXED_UTF8_TO_UTF16_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("decoder assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("decoder assertion failed");

`endif

// ===== rtl/pu8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// pu8u16_pkg
// Types and constants shared by the length-prefixed UTF-8 decoder modules.
// ----------------------------------------------------------------------------
package pu8u16_pkg;

   localparam int BYTE_W       = 8;
   localparam int CODE_W       = 16;
   localparam int COUNT_W      = 28;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QLEVEL_W     = $clog2(QUEUE_DEPTH + 1);

   // Lead byte thresholds (prefix and UTF-8 lead share all but LIM_TWO)
   localparam logic [BYTE_W-1:0] LIM_ONE   = 8'h80;
   localparam logic [BYTE_W-1:0] LIM_TWO   = 8'hC0;
   localparam logic [BYTE_W-1:0] LIM_THREE = 8'hE0;
   localparam logic [BYTE_W-1:0] LIM_FOUR  = 8'hF0;

   typedef enum logic [1:0] {
      PH_PREFIX = 2'd0,
      PH_DECODE = 2'd1,
      PH_SKIP   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [CODE_W-1:0] code_unit;
      logic              has_char;
      logic              last;
      logic              error;
   } rsp_item_type;

   typedef struct packed {
      logic                full;
      logic [QLEVEL_W-1:0] level;
   } queue_status_type;

endpackage

// ===== rtl/pu8u16_req_if.sv =====
// ----------------------------------------------------------------------------
// pu8u16_req_if
// Byte input channel: valid/ready handshake with one raw stream byte.
// ----------------------------------------------------------------------------
interface pu8u16_req_if;
   import pu8u16_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== rtl/pu8u16_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pu8u16_rsp_if
// Result channel: valid/ready handshake with one decoded code unit and flags.
// ----------------------------------------------------------------------------
interface pu8u16_rsp_if;
   import pu8u16_pkg::*;

   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] code_unit;
   logic              has_char;
   logic              last;
   logic              error;

   modport source (output valid, output code_unit, output has_char, output last,
                   output error, input ready);
   modport sink   (input valid, input code_unit, input has_char, input last,
                   input error, output ready);
endinterface

// ===== rtl/pu8u16_front.sv =====
// ----------------------------------------------------------------------------
// pu8u16_front
// Per-byte parser: length prefix accumulation, UTF-8 sequence assembly and
// string skipping. Produces at most one result transaction per byte.
// ----------------------------------------------------------------------------
module pu8u16_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [pu8u16_pkg::BYTE_W-1:0] data_byte,
   output logic                         push,
   output pu8u16_pkg::rsp_item_type     item
);
   import pu8u16_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [1:0]         pbl_ff, pbl_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CODE_W-1:0]  partial_ff, partial_in;
   logic [1:0]         cont_ff, cont_in;

   logic [COUNT_W-1:0] count_dec;
   logic               fin;
   logic [CODE_W-1:0]  sum;
   logic               prefix_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_PREFIX;
         pbl_ff     <= '0;
         count_ff   <= '0;
         partial_ff <= '0;
         cont_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         pbl_ff     <= pbl_in;
         count_ff   <= count_in;
         partial_ff <= partial_in;
         cont_ff    <= cont_in;
      end
   end

   assign count_dec = count_ff - {{(COUNT_W-1){1'b0}}, 1'b1};
   assign fin       = (count_dec == '0);
   assign sum       = (cont_ff == 2'd2) ?
                      (partial_ff + {4'b0, data_byte[5:0], 6'b0}) :
                      (partial_ff + {10'b0, data_byte[5:0]});

   always_comb begin
      phase_in   = phase_ff;
      pbl_in     = pbl_ff;
      count_in   = count_ff;
      partial_in = partial_ff;
      cont_in    = cont_ff;
      push       = 1'b0;
      item       = '0;
      prefix_end = 1'b0;

      if (accept) begin
         case (phase_ff)
            PH_DECODE, PH_SKIP: begin
               count_in = count_dec;
               if ((phase_ff == PH_SKIP) && !fin) begin
                  // drop skipped bytes; the final one is decoded as a lead
                  phase_in = PH_SKIP;
               end else begin
                  phase_in = fin ? PH_PREFIX : PH_DECODE;
                  if (cont_ff == 2'd0) begin
                     if (data_byte < LIM_ONE) begin
                        push           = 1'b1;
                        item.code_unit = {8'b0, data_byte};
                        item.has_char  = 1'b1;
                        item.last      = fin;
                     end else if (data_byte < LIM_FOUR) begin
                        if (data_byte < LIM_THREE) begin
                           partial_in = {5'b0, data_byte[4:0], 6'b0};
                           cont_in    = 2'd1;
                        end else begin
                           partial_in = {data_byte[3:0], 12'b0};
                           cont_in    = 2'd2;
                        end
                        // string ends inside the sequence: flag truncation
                        if (fin) begin
                           partial_in = '0;
                           cont_in    = '0;
                           push       = 1'b1;
                           item.last  = 1'b1;
                           item.error = 1'b1;
                        end
                     end else begin
                        // bad lead byte: drop the rest of the string but its final byte
                        partial_in = '0;
                        phase_in   = fin ? PH_PREFIX : PH_SKIP;
                        push       = 1'b1;
                        item.last  = fin;
                        item.error = 1'b1;
                     end
                  end else begin
                     cont_in = cont_ff - 2'd1;
                     if (cont_ff == 2'd1) begin
                        push           = 1'b1;
                        item.code_unit = sum;
                        item.has_char  = 1'b1;
                        item.last      = fin;
                        partial_in     = '0;
                     end else begin
                        partial_in = sum;
                        if (fin) begin
                           partial_in = '0;
                           cont_in    = '0;
                           push       = 1'b1;
                           item.last  = 1'b1;
                           item.error = 1'b1;
                        end
                     end
                  end
               end
            end
            default: begin
               if (pbl_ff == 2'd0) begin
                  phase_in = PH_PREFIX;
                  if (data_byte < LIM_ONE) begin
                     count_in   = {{(COUNT_W-BYTE_W){1'b0}}, data_byte};
                     prefix_end = 1'b1;
                  end else if (data_byte < LIM_TWO) begin
                     count_in = {{(COUNT_W-6){1'b0}}, data_byte[5:0]};
                     pbl_in   = 2'd1;
                  end else if (data_byte < LIM_THREE) begin
                     count_in = {{(COUNT_W-5){1'b0}}, data_byte[4:0]};
                     pbl_in   = 2'd2;
                  end else if (data_byte < LIM_FOUR) begin
                     count_in = {{(COUNT_W-4){1'b0}}, data_byte[3:0]};
                     pbl_in   = 2'd3;
                  end else begin
                     count_in   = '0;
                     push       = 1'b1;
                     item.last  = 1'b1;
                     item.error = 1'b1;
                  end
               end else begin
                  count_in   = {count_ff[COUNT_W-BYTE_W-1:0], data_byte};
                  pbl_in     = pbl_ff - 2'd1;
                  prefix_end = (pbl_ff == 2'd1);
               end
               if (prefix_end) begin
                  cont_in    = '0;
                  partial_in = '0;
                  if (count_in == '0) begin
                     // empty string: report its end straight away
                     phase_in  = PH_PREFIX;
                     push      = 1'b1;
                     item.last = 1'b1;
                  end else begin
                     phase_in = PH_DECODE;
                  end
               end
            end
         endcase
      end
   end

endmodule

// ===== rtl/pu8u16_queue.sv =====
// ----------------------------------------------------------------------------
// pu8u16_queue
// Result queue between the parser and the output channel; the head entry
// drives the result channel directly.
// ----------------------------------------------------------------------------
module pu8u16_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  pu8u16_pkg::rsp_item_type       push_item,
   input  logic                           pop,
   output pu8u16_pkg::rsp_item_type       head_item,
   output logic                           head_valid,
   output pu8u16_pkg::queue_status_type   status
);
   import pu8u16_pkg::*;

   rsp_item_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QLEVEL_W-1:0] level_ff, level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + {{(QPTR_W-1){1'b0}}, 1'b1} : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + {{(QPTR_W-1){1'b0}}, 1'b1} : rd_ptr_ff;
      case ({push, pop})
         2'b10:   level_in = level_ff + {{(QLEVEL_W-1){1'b0}}, 1'b1};
         2'b01:   level_in = level_ff - {{(QLEVEL_W-1){1'b0}}, 1'b1};
         default: level_in = level_ff;
      endcase
   end

   assign head_item    = mem_ff[rd_ptr_ff];
   assign head_valid   = (level_ff != '0);
   assign status.full  = (level_ff == QLEVEL_W'(QUEUE_DEPTH));
   assign status.level = level_ff;

endmodule

// ===== rtl/prefixed_utf8_to_utf16_decoder.sv =====
// ----------------------------------------------------------------------------
// prefixed_utf8_to_utf16_decoder
// Length-prefixed UTF-8 byte stream to UTF-16 code unit decoder.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one stream byte per transaction. Each string starts with a
//   big-endian length prefix of 1 to 4 bytes, then that many UTF-8 bytes.
//   rsp_if carries a result transaction when a character completes, on the
//   last byte of a string, or on an error (bad prefix lead, bad UTF-8 lead,
//   truncated sequence). Bytes that cause no result produce nothing.
//   Each result is registered in the result queue and offered on rsp_if
//   once the results ahead of it are taken. Throughput: one byte per cycle
//   while the 4-entry result queue has free space; the parser state updates
//   with each accepted byte, so the byte rate is set only by that free space.
//   Stall: while rsp_if.ready is low the queue fills; req_if.ready drops only
//   once all 4 entries hold results, and rises in the cycle after one is taken.
//   Reset: synchronous; the parser returns to reading a length prefix and
//   the queue empties. No clearing pass follows.
// ----------------------------------------------------------------------------
module prefixed_utf8_to_utf16_decoder (
   input  logic          clock,
   input  logic          reset,
   pu8u16_req_if.sink    req_if,
   pu8u16_rsp_if.source  rsp_if
);
   import pu8u16_pkg::*;

   `include "prefixed_utf8_to_utf16_decoder_assert.svh"

   logic             req_accept;
   logic             push;
   logic             pop;
   logic             head_valid;
   rsp_item_type     push_item;
   rsp_item_type     head_item;
   queue_status_type q_status;

   assign req_if.ready = !q_status.full;
   assign req_accept   = req_if.valid && req_if.ready;
   assign pop          = rsp_if.valid && rsp_if.ready;

   pu8u16_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_if.data_byte),
      .push      (push),
      .item      (push_item)
   );

   pu8u16_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_item  (head_item),
      .head_valid (head_valid),
      .status     (q_status)
   );

   assign rsp_if.valid     = head_valid;
   assign rsp_if.code_unit = head_item.code_unit;
   assign rsp_if.has_char  = head_item.has_char;
   assign rsp_if.last      = head_item.last;
   assign rsp_if.error     = head_item.error;

   `PU_ASSERT_NEXT(a_push_shows, clock, reset, push && (q_status.level == '0), rsp_if.valid)
   `PU_ASSERT_SAME(a_level_bound, clock, reset, 1'b1, q_status.level <= QLEVEL_W'(QUEUE_DEPTH))
   `PU_ASSERT_SAME(a_char_no_err, clock, reset, rsp_if.valid, !(rsp_if.has_char && rsp_if.error))
   `PU_ASSERT_SAME(a_nochar_zero, clock, reset, rsp_if.valid && !rsp_if.has_char, rsp_if.code_unit == '0)

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for prefixed_utf8_to_utf16_decoder
// Drives length-prefixed UTF-8 strings into the byte channel and checks every
// result transaction against a cycle-free model of the decoder kept in a
// small scoreboard class. A short set of hand-picked strings comes first, then
// random strings with random content, truncations and bad leads. Both sides
// idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module testbench;
   import pu8u16_pkg::*;

   localparam int ITEM_TARGET  = 1700;
   localparam int CALM_FROM    = 1450;
   localparam int IDLE_LIMIT   = 200;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS  = 20;

   // empty string; 2-byte prefix with ASCII extremes and a 2-byte character;
   // 3-byte prefix with the highest 3-byte character; 4-byte prefix with a
   // stray continuation as lead; bad prefix lead; bad UTF-8 lead then skip;
   // sequence cut short by the end of its string
   localparam logic [BYTE_W-1:0] OPENING_BYTES [27] = '{
      8'h00,
      8'h80, 8'h04, 8'h00, 8'h7F, 8'hC2, 8'hA9,
      8'hC0, 8'h00, 8'h03, 8'hEF, 8'hBF, 8'hBF,
      8'hE0, 8'h00, 8'h00, 8'h02, 8'hBF, 8'h80,
      8'hFF,
      8'h03, 8'hF0, 8'h41, 8'hC3,
      8'h02, 8'hE2, 8'h82
   };
   localparam int OPENING_STRINGS = 7;

   class utf16_tracker;
      phase_type          phase;
      logic [1:0]         prefix_left;
      logic [COUNT_W-1:0] remaining;
      logic [CODE_W-1:0]  partial;
      logic [1:0]         conts_left;
      rsp_item_type       units_due[$];
      int                 mismatches;
      int                 results;
      int                 chars;
      int                 errors;

      function new();
         phase       = PH_PREFIX;
         prefix_left = '0;
         remaining   = '0;
         partial     = '0;
         conts_left  = '0;
         mismatches  = 0;
         results     = 0;
         chars       = 0;
         errors      = 0;
      endfunction

      function void queue_unit(logic [CODE_W-1:0] cu, logic hc, logic lst, logic err);
         rsp_item_type r;
         r.code_unit = cu;
         r.has_char  = hc;
         r.last      = lst;
         r.error     = err;
         units_due.push_back(r);
      endfunction

      function void close_prefix();
         conts_left = '0;
         partial    = '0;
         if (remaining == 0) begin
            phase = PH_PREFIX;
            queue_unit('0, 1'b0, 1'b1, 1'b0);
         end else begin
            phase = PH_DECODE;
         end
      endfunction

      function void take_byte(logic [BYTE_W-1:0] b);
         logic        fin;
         logic [31:0] wide;
         if (phase == PH_DECODE || phase == PH_SKIP) begin
            remaining = remaining - COUNT_W'(1);
            fin = (remaining == 0);
            if (fin)
               phase = PH_PREFIX;
            // the final byte of a skipped string has left the skip phase and
            // goes through the decoder like any lead byte
            if (phase == PH_SKIP)
               return;
            if (conts_left == 0) begin
               if (b < LIM_ONE) begin
                  queue_unit({8'h00, b}, 1'b1, fin, 1'b0);
                  return;
               end else if (b < LIM_THREE) begin
                  wide       = {24'h0, b} << 6;
                  partial    = wide[15:0] & 16'h07FF;
                  conts_left = 2'd1;
               end else if (b < LIM_FOUR) begin
                  wide       = {24'h0, b} << 12;
                  partial    = wide[15:0];
                  conts_left = 2'd2;
               end else begin
                  partial = '0;
                  if (!fin)
                     phase = PH_SKIP;
                  queue_unit('0, 1'b0, fin, 1'b1);
                  return;
               end
            end else begin
               wide       = {26'h0, b[5:0]} << ((conts_left == 2'd2) ? 6 : 0);
               partial    = partial + wide[15:0];
               conts_left = conts_left - 2'd1;
               if (conts_left == 0) begin
                  queue_unit(partial, 1'b1, fin, 1'b0);
                  partial = '0;
                  return;
               end
            end
            // string ended inside a sequence: drop the partial character
            if (fin) begin
               partial    = '0;
               conts_left = '0;
               queue_unit('0, 1'b0, 1'b1, 1'b1);
            end
            return;
         end

         if (prefix_left == 0) begin
            phase = PH_PREFIX;
            if (b < LIM_ONE) begin
               remaining = COUNT_W'(b);
               close_prefix();
            end else if (b < LIM_TWO) begin
               remaining   = COUNT_W'(b & 8'h3F);
               prefix_left = 2'd1;
            end else if (b < LIM_THREE) begin
               remaining   = COUNT_W'(b & 8'h1F);
               prefix_left = 2'd2;
            end else if (b < LIM_FOUR) begin
               remaining   = COUNT_W'(b & 8'h0F);
               prefix_left = 2'd3;
            end else begin
               remaining = '0;
               queue_unit('0, 1'b0, 1'b1, 1'b1);
            end
            return;
         end
         remaining   = {remaining[COUNT_W-9:0], b};
         prefix_left = prefix_left - 2'd1;
         if (prefix_left == 0)
            close_prefix();
      endfunction

      task flag_mismatch(string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, what);
      endtask

      task check_unit(rsp_item_type got);
         rsp_item_type want;
         results++;
         if (got.has_char)
            chars++;
         if (got.error)
            errors++;
         if (units_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected result unit=%h char=%b last=%b err=%b",
                                    got.code_unit, got.has_char, got.last, got.error));
            return;
         end
         want = units_due.pop_front();
         if (got.code_unit !== want.code_unit)
            flag_mismatch($sformatf("code_unit %h, want %h", got.code_unit, want.code_unit));
         if (got.has_char !== want.has_char)
            flag_mismatch($sformatf("has_char %b, want %b", got.has_char, want.has_char));
         if (got.last !== want.last)
            flag_mismatch($sformatf("last %b, want %b", got.last, want.last));
         if (got.error !== want.error)
            flag_mismatch($sformatf("error %b, want %b", got.error, want.error));
      endtask
   endclass

   logic         clock;
   logic         reset;
   int           src_idle_pct;
   int           snk_stall_pct;
   int           bytes_sent;
   int           strings_sent;
   int           quiet_cycles;
   utf16_tracker tracker;

   pu8u16_req_if req_bus();
   pu8u16_rsp_if rsp_bus();

   prefixed_utf8_to_utf16_decoder DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // transaction monitors
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         tracker.take_byte(req_bus.data_byte);
   end

   always @(posedge clock) begin
      rsp_item_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.code_unit = rsp_bus.code_unit;
         got.has_char  = rsp_bus.has_char;
         got.last      = rsp_bus.last;
         got.error     = rsp_bus.error;
         tracker.check_unit(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= IDLE_LIMIT) begin
            $display("no transaction for %0d cycles", IDLE_LIMIT);
            $display("[prefixed_utf8_to_utf16_decoder] ERROR");
            $finish;
         end
      end
   end

   // result side: hold ready low in random bursts
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if ($urandom_range(1, 100) <= snk_stall_pct) begin
            rsp_bus.ready <= 1'b0;
            stall = $urandom_range(1, 5);
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      int gap;
      if ($urandom_range(1, 100) <= src_idle_pct) begin
         req_bus.valid <= 1'b0;
         gap = $urandom_range(1, 5);
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] tail_byte();
      // continuations are not checked, so now and then send any byte
      if ($urandom_range(0, 7) == 0)
         return BYTE_W'($urandom_range(0, 255));
      return BYTE_W'($urandom_range(8'h80, 8'hBF));
   endfunction

   task automatic send_random_string();
      logic [BYTE_W-1:0]  body[$];
      logic [COUNT_W-1:0] len;
      int                 target;
      int                 pick;
      int                 size_min;
      if ($urandom_range(0, 19) == 0)
         push_byte(BYTE_W'($urandom_range(8'hF0, 8'hFF)));
      if ($urandom_range(0, 39) == 0)
         target = $urandom_range(130, 300);
      else
         target = $urandom_range(0, 12);
      while (body.size() < target) begin
         pick = $urandom_range(0, 19);
         if (pick < 8) begin
            body.push_back(BYTE_W'($urandom_range(0, 8'h7F)));
         end else if (pick < 12) begin
            body.push_back(BYTE_W'($urandom_range(8'hC0, 8'hDF)));
            body.push_back(tail_byte());
         end else if (pick < 16) begin
            body.push_back(BYTE_W'($urandom_range(8'hE0, 8'hEF)));
            body.push_back(tail_byte());
            body.push_back(tail_byte());
         end else if (pick == 16) begin
            body.push_back(BYTE_W'($urandom_range(8'hF0, 8'hFF)));
         end else if (pick == 17) begin
            body.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
            body.push_back(tail_byte());
         end else begin
            body.push_back(BYTE_W'($urandom_range(0, 255)));
         end
      end
      // cut the tail off now and then to leave a sequence unfinished
      if (body.size() > 0 && $urandom_range(0, 4) == 0) begin
         void'(body.pop_back());
         if (body.size() > 0 && $urandom_range(0, 1) == 0)
            void'(body.pop_back());
      end
      len = COUNT_W'(body.size());
      size_min = (len < 128) ? 1 : (len < 16384) ? 2 : 3;
      case ($urandom_range(size_min, 4))
         1: begin
            push_byte(len[7:0]);
         end
         2: begin
            push_byte({2'b10, len[13:8]});
            push_byte(len[7:0]);
         end
         3: begin
            push_byte({3'b110, len[20:16]});
            push_byte(len[15:8]);
            push_byte(len[7:0]);
         end
         default: begin
            push_byte({4'b1110, len[27:24]});
            push_byte(len[23:16]);
            push_byte(len[15:8]);
            push_byte(len[7:0]);
         end
      endcase
      foreach (body[i])
         push_byte(body[i]);
      strings_sent++;
   endtask

   initial begin
      tracker           = new();
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      src_idle_pct      = 20;
      snk_stall_pct     = 20;
      bytes_sent        = 0;
      strings_sent      = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (OPENING_BYTES[i])
         push_byte(OPENING_BYTES[i]);
      strings_sent += OPENING_STRINGS;

      while (bytes_sent < ITEM_TARGET) begin
         if (bytes_sent >= CALM_FROM) begin
            src_idle_pct  = 0;
            snk_stall_pct = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            src_idle_pct  = 0;
            snk_stall_pct = 0;
         end else begin
            src_idle_pct  = $urandom_range(0, 2) * 20;
            snk_stall_pct = $urandom_range(0, 2) * 20;
         end
         send_random_string();
      end
      req_bus.valid <= 1'b0;

      while (tracker.units_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d bytes in %0d strings", bytes_sent, strings_sent);
      $display("checked %0d results: %0d characters, %0d flagged errors, %0d mismatches",
               tracker.results, tracker.chars, tracker.errors, tracker.mismatches);
      if (tracker.mismatches == 0)
         $display("[prefixed_utf8_to_utf16_decoder] OK");
      else
         $display("[prefixed_utf8_to_utf16_decoder] ERROR");
      $finish;
   end

endmodule
